// File: design/nram_pkg.sv
// nram_pkg: shared types, codes and constants of the flash request address mapper
// depends on nothing; used by the interfaces, the divider cell and the top level
`default_nettype none

package nram_pkg;

    // logical offset bits that take part in the mapping
    localparam int ADDR_BITS = 40;

    localparam int OFS_W    = 40;
    localparam int LEN_W    = 32;
    localparam int SPL_W    = 13;
    localparam int PAGE_W   = 17;
    localparam int SPARE_W  = 13;
    localparam int ERASE_W  = 25;
    localparam int DEV_W    = 41;
    localparam int RAW_W    = 42;
    localparam int STRIDE_W = 18;
    localparam int CFG_W    = 41;
    localparam int CIDX_W   = 3;

    // divider chain: one quotient bit per cell, four lanes side by side
    localparam int DIV_STEPS = OFS_W;
    localparam int NLANES    = 4;
    localparam int REM_W     = ERASE_W;

    localparam logic [OFS_W-1:0] OFS_MASK =
        (ADDR_BITS >= OFS_W) ? {OFS_W{1'b1}} : OFS_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

    // lane numbers
    localparam int LN_OFS_P = 0;
    localparam int LN_LEN_P = 1;
    localparam int LN_OFS_E = 2;
    localparam int LN_ERS_P = 3;

    typedef enum logic [2:0] {
        RT_READ       = 3'd0,
        RT_WRITE      = 3'd1,
        RT_ERASE      = 3'd2,
        RT_READ_SPARE = 3'd3,
        RT_WRITE_SPARE= 3'd4,
        RT_BAD_QUERY  = 3'd5,
        RT_BAD_MARK   = 3'd6,
        RT_UNUSED     = 3'd7
    } rtype_t;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_READ    = 3'd1,
        CMD_WRITE   = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_BAD_GET = 3'd4,
        CMD_BAD_SET = 3'd5
    } cmd_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_PAGE   = 3'd0,
        CFG_SPARE  = 3'd1,
        CFG_ERASE  = 3'd2,
        CFG_DEVICE = 3'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
        logic             has_data;
        logic             has_spare;
        logic [SPL_W-1:0] spare_length;
        logic [SPL_W-1:0] spare_offset;
    } req_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [OFS_W-1:0] dq;
    } lane_t;

    typedef struct packed {
        logic                   valid;
        req_t                   req;
        lane_t [NLANES-1:0]     lane;
    } stage_t;

    typedef logic [NLANES-1:0][REM_W-1:0] divs_t;

    typedef struct packed {
        logic             status;
        logic [2:0]       command;
        logic [RAW_W-1:0] raw_address;
        logic [LEN_W-1:0] raw_length;
        logic             last;
    } res_t;

endpackage

`default_nettype wire

// File: design/nram_req_if.sv
// nram_req_if: request channel, valid/ready handshake with the request fields
// depends on nram_pkg for field widths
`default_nettype none

interface nram_req_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  req_type;
    logic [nram_pkg::OFS_W-1:0]  offset;
    logic [nram_pkg::LEN_W-1:0]  length;
    logic                        has_data;
    logic                        has_spare;
    logic [nram_pkg::SPL_W-1:0]  spare_length;
    logic [nram_pkg::SPL_W-1:0]  spare_offset;

    modport source (output valid, req_type, offset, length, has_data, has_spare,
                    spare_length, spare_offset, input ready);
    modport sink   (input valid, req_type, offset, length, has_data, has_spare,
                    spare_length, spare_offset, output ready);
endinterface

`default_nettype wire

// File: design/nram_rsp_if.sv
// nram_rsp_if: result channel, valid/ready handshake with the result fields
// depends on nram_pkg for field widths
`default_nettype none

interface nram_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [2:0]                  command;
    logic [nram_pkg::RAW_W-1:0]  raw_address;
    logic [nram_pkg::LEN_W-1:0]  raw_length;
    logic                        last;

    modport source (output valid, status, command, raw_address, raw_length, last,
                    input ready);
    modport sink   (input valid, status, command, raw_address, raw_length, last,
                    output ready);
endinterface

`default_nettype wire

// File: design/nand_request_address_mapper.sv
// path from request to first result word: 40 divider cells, 2 multiply stages, output holder;
// the second word of a two-word request is shown in the cycle after the first word is taken
// throughput: one request per cycle, set by the divider chain, while the output holder does
// not stall it; a two-word request holds the output holder and the whole chain until its second word is taken
// reset: asynchronous active low; clears valid bits and loads the geometry reset values
`default_nettype none

module nand_request_address_mapper (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [nram_pkg::CIDX_W-1:0]       cfg_index,
    input  wire [nram_pkg::CFG_W-1:0]        cfg_data,
    nram_req_if.sink                         req,
    nram_rsp_if.source                       rsp
);

    localparam int SW = nram_pkg::STRIDE_W;
    localparam int PW = nram_pkg::OFS_W + SW;
    localparam int SPL_SUM_W = nram_pkg::SPL_W + 1;

    // geometry registers
    logic [nram_pkg::PAGE_W-1:0]  page_reg;
    logic [nram_pkg::SPARE_W-1:0] spare_reg;
    logic [nram_pkg::ERASE_W-1:0] erase_reg;
    logic [nram_pkg::DEV_W-1:0]   dev_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg  <= nram_pkg::PAGE_W'(2048);
            spare_reg <= nram_pkg::SPARE_W'(64);
            erase_reg <= nram_pkg::ERASE_W'(131072);
            dev_reg   <= nram_pkg::DEV_W'(268435456);
        end
        else if (cfg_we)
        begin
            case (nram_pkg::cfg_idx_t'(cfg_index))
                nram_pkg::CFG_PAGE:   page_reg  <= cfg_data[nram_pkg::PAGE_W-1:0];
                nram_pkg::CFG_SPARE:  spare_reg <= cfg_data[nram_pkg::SPARE_W-1:0];
                nram_pkg::CFG_ERASE:  erase_reg <= cfg_data[nram_pkg::ERASE_W-1:0];
                nram_pkg::CFG_DEVICE: dev_reg   <= cfg_data[nram_pkg::DEV_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SW-1:0] stride;
    assign stride = SW'(page_reg) + SW'(spare_reg);

    // chain enable, driven by the output holder
    logic ce;
    assign req.ready = ce;

    // divisors per lane
    nram_pkg::divs_t divs;
    assign divs[nram_pkg::LN_OFS_P] = nram_pkg::REM_W'(page_reg);
    assign divs[nram_pkg::LN_LEN_P] = nram_pkg::REM_W'(page_reg);
    assign divs[nram_pkg::LN_OFS_E] = erase_reg;
    assign divs[nram_pkg::LN_ERS_P] = nram_pkg::REM_W'(page_reg);

    // word entering the first cell
    nram_pkg::stage_t s_in;
    logic [nram_pkg::OFS_W-1:0] ofs_m;
    assign ofs_m = req.offset & nram_pkg::OFS_MASK;

    always_comb
    begin
        s_in.valid            = req.valid;
        s_in.req.req_type     = req.req_type;
        s_in.req.offset       = ofs_m;
        s_in.req.length       = req.length;
        s_in.req.has_data     = req.has_data;
        s_in.req.has_spare    = req.has_spare;
        s_in.req.spare_length = req.spare_length;
        s_in.req.spare_offset = req.spare_offset;
        for (int i = 0; i < nram_pkg::NLANES; i++)
        begin
            s_in.lane[i].rem = '0;
        end
        s_in.lane[nram_pkg::LN_OFS_P].dq = ofs_m;
        s_in.lane[nram_pkg::LN_LEN_P].dq = nram_pkg::OFS_W'(req.length);
        s_in.lane[nram_pkg::LN_OFS_E].dq = ofs_m;
        s_in.lane[nram_pkg::LN_ERS_P].dq = nram_pkg::OFS_W'(erase_reg);
    end

    // divider chain
    nram_pkg::stage_t s [nram_pkg::DIV_STEPS+1];
    assign s[0] = s_in;

    for (genvar k = 0; k < nram_pkg::DIV_STEPS; k++)
    begin : g_cell
        nram_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ce        (ce),
            .divs      (divs),
            .stage_in  (s[k]),
            .stage_out (s[k+1])
        );
    end

    nram_pkg::stage_t s_end;
    assign s_end = s[nram_pkg::DIV_STEPS];

    // first multiply stage: page address, erase raw length, first page of the block
    logic                        a_valid_reg;
    nram_pkg::req_t              a_req_reg;
    logic                        a_ofs_pal_reg, a_len_pal_reg, a_ofs_eal_reg;
    logic [PW-1:0]               a_raw_pg_reg;
    logic [nram_pkg::LEN_W-1:0]  a_rlen_reg;
    logic [nram_pkg::OFS_W-1:0]  a_m1_reg;

    logic [nram_pkg::LEN_W+SW-1:0]            a_rlen_full;
    logic [nram_pkg::OFS_W+nram_pkg::ERASE_W-1:0] a_m1_full;
    assign a_rlen_full = (nram_pkg::LEN_W+SW)'(s_end.lane[nram_pkg::LN_LEN_P].dq[nram_pkg::LEN_W-1:0])
                       * (nram_pkg::LEN_W+SW)'(stride);
    assign a_m1_full   = (nram_pkg::OFS_W+nram_pkg::ERASE_W)'(s_end.lane[nram_pkg::LN_OFS_E].dq)
                       * (nram_pkg::OFS_W+nram_pkg::ERASE_W)'(
                             s_end.lane[nram_pkg::LN_ERS_P].dq[nram_pkg::ERASE_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            a_valid_reg <= s_end.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_req_reg     <= s_end.req;
            a_ofs_pal_reg <= (s_end.lane[nram_pkg::LN_OFS_P].rem == '0);
            a_len_pal_reg <= (s_end.lane[nram_pkg::LN_LEN_P].rem == '0);
            a_ofs_eal_reg <= (s_end.lane[nram_pkg::LN_OFS_E].rem == '0);
            a_raw_pg_reg  <= PW'(s_end.lane[nram_pkg::LN_OFS_P].dq) * PW'(stride);
            a_rlen_reg    <= a_rlen_full[nram_pkg::LEN_W-1:0];
            a_m1_reg      <= a_m1_full[nram_pkg::OFS_W-1:0];
        end
    end

    // second multiply stage: bad-block address
    logic                        b_valid_reg;
    nram_pkg::req_t              b_req_reg;
    logic                        b_ofs_pal_reg, b_len_pal_reg, b_ofs_eal_reg;
    logic [PW-1:0]               b_raw_pg_reg;
    logic [PW-1:0]               b_raw_bad_reg;
    logic [nram_pkg::LEN_W-1:0]  b_rlen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            b_req_reg     <= a_req_reg;
            b_ofs_pal_reg <= a_ofs_pal_reg;
            b_len_pal_reg <= a_len_pal_reg;
            b_ofs_eal_reg <= a_ofs_eal_reg;
            b_raw_pg_reg  <= a_raw_pg_reg;
            b_rlen_reg    <= a_rlen_reg;
            b_raw_bad_reg <= PW'(a_m1_reg) * PW'(stride);
        end
    end

    // checks and result words
    nram_pkg::res_t r0, r1;
    logic           two;

    always_comb
    begin
        logic                        inv;
        logic [nram_pkg::DEV_W-1:0]  end_ofs;
        logic [SPL_SUM_W-1:0]        sp_end;
        logic [PW:0]                 sp_addr;
        logic [nram_pkg::RAW_W-1:0]  raw_pg_sat;
        logic [nram_pkg::RAW_W-1:0]  raw_bad_sat;
        logic [nram_pkg::RAW_W-1:0]  sp_sat;
        logic [2:0]                  rw_cmd;
        nram_pkg::rtype_t            rt;

        rt       = nram_pkg::rtype_t'(b_req_reg.req_type);
        end_ofs  = nram_pkg::DEV_W'(b_req_reg.offset) + nram_pkg::DEV_W'(b_req_reg.length);
        sp_end   = SPL_SUM_W'(b_req_reg.spare_length) + SPL_SUM_W'(b_req_reg.spare_offset);
        sp_addr  = (PW+1)'(b_raw_pg_reg) + (PW+1)'(page_reg) + (PW+1)'(b_req_reg.spare_offset);
        raw_pg_sat  = (b_raw_pg_reg  > PW'(nram_pkg::RAW_MAX)) ? nram_pkg::RAW_MAX
                                                            : b_raw_pg_reg[nram_pkg::RAW_W-1:0];
        raw_bad_sat = (b_raw_bad_reg > PW'(nram_pkg::RAW_MAX)) ? nram_pkg::RAW_MAX
                                                            : b_raw_bad_reg[nram_pkg::RAW_W-1:0];
        sp_sat      = (sp_addr > (PW+1)'(nram_pkg::RAW_MAX)) ? nram_pkg::RAW_MAX
                                                            : sp_addr[nram_pkg::RAW_W-1:0];
        rw_cmd   = (rt == nram_pkg::RT_READ_SPARE) ? nram_pkg::CMD_READ : nram_pkg::CMD_WRITE;

        inv = 1'b0;
        r0  = '{status: 1'b0, command: nram_pkg::CMD_NONE, raw_address: '0,
                raw_length: '0, last: 1'b1};
        r1  = r0;
        two = 1'b0;

        case (rt)
            nram_pkg::RT_BAD_QUERY, nram_pkg::RT_BAD_MARK:
            begin
                inv = ({1'b0, b_req_reg.offset} >= dev_reg) || (erase_reg == '0)
                   || !b_ofs_eal_reg;
                r0.command     = (rt == nram_pkg::RT_BAD_QUERY) ? nram_pkg::CMD_BAD_GET
                                                                : nram_pkg::CMD_BAD_SET;
                r0.raw_address = raw_bad_sat;
            end
            nram_pkg::RT_READ, nram_pkg::RT_WRITE:
            begin
                inv = (end_ofs > dev_reg)
                   || (b_req_reg.length != nram_pkg::LEN_W'(page_reg)) || !b_ofs_pal_reg;
                r0.command     = (rt == nram_pkg::RT_READ) ? nram_pkg::CMD_READ
                                                           : nram_pkg::CMD_WRITE;
                r0.raw_address = raw_pg_sat;
                r0.raw_length  = b_req_reg.length;
            end
            nram_pkg::RT_ERASE:
            begin
                inv = (end_ofs > dev_reg) || !b_ofs_pal_reg || !b_len_pal_reg;
                r0.command     = nram_pkg::CMD_ERASE;
                r0.raw_address = raw_pg_sat;
                r0.raw_length  = b_rlen_reg;
            end
            nram_pkg::RT_READ_SPARE, nram_pkg::RT_WRITE_SPARE:
            begin
                inv = (end_ofs > dev_reg)
                   || ((b_req_reg.length != '0)
                       && (b_req_reg.length != nram_pkg::LEN_W'(page_reg))
                       && ((rt == nram_pkg::RT_WRITE_SPARE) || b_req_reg.has_data))
                   || (sp_end > SPL_SUM_W'(spare_reg))
                   || !b_ofs_pal_reg;
                if (b_req_reg.has_data)
                begin
                    r0.command     = rw_cmd;
                    r0.raw_address = raw_pg_sat;
                    r0.raw_length  = b_req_reg.length;
                    r0.last        = !b_req_reg.has_spare;
                    r1.command     = rw_cmd;
                    r1.raw_address = sp_sat;
                    r1.raw_length  = nram_pkg::LEN_W'(b_req_reg.spare_length);
                    two            = b_req_reg.has_spare;
                end
                else if (b_req_reg.has_spare)
                begin
                    r0.command     = rw_cmd;
                    r0.raw_address = sp_sat;
                    r0.raw_length  = nram_pkg::LEN_W'(b_req_reg.spare_length);
                end
            end
            default:
            begin
                inv = 1'b1;
            end
        endcase

        if (inv || (page_reg == '0))
        begin
            r0  = '{status: 1'b1, command: nram_pkg::CMD_NONE, raw_address: '0,
                    raw_length: '0, last: 1'b1};
            two = 1'b0;
        end
    end

    // output holder, gives one or two words per request
    logic           hold_valid_reg;
    logic           idx_reg;
    logic           two_reg;
    nram_pkg::res_t res0_reg, res1_reg;
    nram_pkg::res_t cur;

    assign cur = idx_reg ? res1_reg : res0_reg;
    assign ce  = !hold_valid_reg || (rsp.ready && cur.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            idx_reg        <= 1'b0;
            two_reg        <= 1'b0;
        end
        else if (ce)
        begin
            hold_valid_reg <= b_valid_reg;
            idx_reg        <= 1'b0;
            two_reg        <= two;
        end
        else if (rsp.ready)
        begin
            idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            res0_reg <= r0;
            res1_reg <= r1;
        end
    end

    assign rsp.valid       = hold_valid_reg;
    assign rsp.status      = cur.status;
    assign rsp.command     = cur.command;
    assign rsp.raw_address = cur.raw_address;
    assign rsp.raw_length  = cur.raw_length;
    assign rsp.last        = cur.last;

`ifndef SYNTH
    // second word only comes from a two-word request
    a_idx_two: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && idx_reg) |-> two_reg)
        else $error("second word shown for a single-word request");

    // a taken first word is followed by the final word
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.last) |=> (rsp.valid && rsp.last))
        else $error("final word missing after first word");

    // a rejected request is a single bare word
    a_inv: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status) |->
        (rsp.last && (rsp.command == nram_pkg::CMD_NONE) && (rsp.raw_address == '0)))
        else $error("invalid result not in its plain form");

    // the chain stands still while a non-final word waits
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> !req.ready)
        else $error("request taken while first word pending");
`endif

endmodule

`default_nettype wire

// File: design/nram_div_cell.sv
// nram_div_cell: one restoring division step for four lanes, registered
// depends on nram_pkg for the stage and lane types
`default_nettype none

module nram_div_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      ce,
    input  wire nram_pkg::divs_t     divs,
    input  wire nram_pkg::stage_t    stage_in,
    output nram_pkg::stage_t         stage_out
);

    logic                                    valid_reg;
    nram_pkg::req_t                          req_reg;
    nram_pkg::lane_t [nram_pkg::NLANES-1:0]  lane_reg;
    nram_pkg::stage_t                        stage_next;

    // one quotient bit per lane
    always_comb
    begin
        logic [nram_pkg::REM_W:0] t;
        logic [nram_pkg::REM_W:0] d;
        logic                     ge;
        stage_next       = stage_in;
        for (int i = 0; i < nram_pkg::NLANES; i++)
        begin
            t  = {stage_in.lane[i].rem, stage_in.lane[i].dq[nram_pkg::OFS_W-1]};
            d  = {1'b0, divs[i]};
            ge = (t >= d);
            stage_next.lane[i].rem = ge ? nram_pkg::REM_W'(t - d)
                                        : t[nram_pkg::REM_W-1:0];
            stage_next.lane[i].dq  = {stage_in.lane[i].dq[nram_pkg::OFS_W-2:0], ge};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            valid_reg <= stage_next.valid;
        end
    end

    // payload and lanes
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            req_reg  <= stage_next.req;
            lane_reg <= stage_next.lane;
        end
    end

    assign stage_out = {valid_reg, req_reg, lane_reg};

endmodule

`default_nettype wire
